// File: src/i2c_bit_level_master_unit_defines.svh
// Assertion helpers for the bit-level master.
// Both expect clk and arst_n in scope.
`ifndef I2C_BIT_LEVEL_MASTER_UNIT_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication
`define I2CBLM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define I2CBLM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/i2cblm_pkg.sv
package i2cblm_pkg;

	// stream widths
	localparam int unsigned TDATA_W = 16;

	// command codes
	localparam logic [2:0] CMD_START = 3'd0;
	localparam logic [2:0] CMD_STOP  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;
	localparam logic [2:0] CMD_NACK  = 3'd5;
	localparam logic [2:0] CMD_RACK  = 3'd6;

	// line select of a phase
	localparam logic LINE_SCL = 1'b0;
	localparam logic LINE_SDA = 1'b1;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd40;
	localparam logic [15:0] HOLD_MAX        = 16'hFFFF;
	localparam logic [4:0]  WRITE_BIT_PHASES = 5'd24;

	// input transaction, first field in the highest bit
	typedef struct packed {
		logic       sda_in;
		logic [7:0] tx_byte;
		logic [2:0] cmd;
		logic       cmd_valid;
	} item_t;

	// result transaction, first field in the highest bit
	typedef struct packed {
		logic       ack_level;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       scl_out;
	} res_t;

	typedef struct packed {
		logic line;
		logic level;
		logic sample;
	} phase_t;

	// number of phases in a command sequence
	function automatic logic [4:0] phase_count(logic [2:0] c);
		logic [4:0] n;
		unique case (c)
			CMD_START: n = 5'd4;
			CMD_STOP:  n = 5'd3;
			CMD_WRITE: n = 5'd25;
			CMD_READ:  n = 5'd16;
			CMD_ACK:   n = 5'd4;
			CMD_NACK:  n = 5'd3;
			CMD_RACK:  n = 5'd2;
			default:   n = 5'd0;
		endcase
		return n;
	endfunction

	// line, level and sample flag of phase p of command c
	function automatic phase_t phase_of(logic [2:0] c, logic [4:0] p, logic [7:0] shift);
		phase_t     ph;
		logic [2:0] k;
		logic [1:0] r;
		ph.line   = LINE_SCL;
		ph.level  = 1'b1;
		ph.sample = 1'b0;
		k = 3'd0;
		r = 2'd0;
		unique case (c)
			CMD_START: begin
				unique case (p)
					5'd0: begin ph.line = LINE_SDA; ph.level = 1'b1; end
					5'd1: begin ph.line = LINE_SCL; ph.level = 1'b1; end
					5'd2: begin ph.line = LINE_SDA; ph.level = 1'b0; end
					5'd3: begin ph.line = LINE_SCL; ph.level = 1'b0; end
					default: ;
				endcase
			end
			CMD_STOP: begin
				unique case (p)
					5'd0: begin ph.line = LINE_SDA; ph.level = 1'b0; end
					5'd1: begin ph.line = LINE_SCL; ph.level = 1'b1; end
					5'd2: begin ph.line = LINE_SDA; ph.level = 1'b1; end
					default: ;
				endcase
			end
			CMD_WRITE: begin
				if (p < WRITE_BIT_PHASES) begin
					// bit index and sub-phase: p = 3*k + r
					for (int i = 0; i < 8; i++) begin
						if (p >= 5'(3 * i)) begin
							k = 3'(i);
							r = 2'(p - 5'(3 * i));
						end
					end
					if (r == 2'd0) begin
						ph.line  = LINE_SDA;
						ph.level = shift[3'd7 - k];
					end else begin
						ph.line  = LINE_SCL;
						ph.level = (r == 2'd1);
					end
				end else begin
					ph.line  = LINE_SDA;
					ph.level = 1'b1;
				end
			end
			CMD_READ, CMD_RACK: begin
				ph.line   = LINE_SCL;
				ph.level  = ~p[0];
				ph.sample = ~p[0];
			end
			CMD_ACK: begin
				unique case (p)
					5'd0: begin ph.line = LINE_SDA; ph.level = 1'b0; end
					5'd1: begin ph.line = LINE_SCL; ph.level = 1'b1; end
					5'd2: begin ph.line = LINE_SCL; ph.level = 1'b0; end
					5'd3: begin ph.line = LINE_SDA; ph.level = 1'b1; end
					default: ;
				endcase
			end
			CMD_NACK: begin
				unique case (p)
					5'd0: begin ph.line = LINE_SDA; ph.level = 1'b1; end
					5'd1: begin ph.line = LINE_SCL; ph.level = 1'b1; end
					5'd2: begin ph.line = LINE_SCL; ph.level = 1'b0; end
					default: ;
				endcase
			end
			default: ;
		endcase
		return ph;
	endfunction

endpackage

// File: src/i2cblm_engine.sv
module i2cblm_engine import i2cblm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] phase_ticks,
	input  logic        fire,
	input  item_t       item,
	output res_t        res
);

	logic       scl_q, sda_q, busy_q, ack_q;
	logic [2:0] cmd_q;
	logic [4:0] phase_q;
	logic [15:0] hold_q;
	logic [7:0] shift_q, rx_q;

	logic       scl_d, sda_d, busy_d, ack_d, done_d, start;
	logic [2:0] cmd_d;
	logic [4:0] phase_d, n_phases;
	logic [15:0] hold_d, limit;
	logic [7:0] shift_d, rx_d;
	phase_t     ph;

	// one tick of the phase sequencer
	always_comb begin
		limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
		start    = !busy_q && item.cmd_valid && (item.cmd <= CMD_RACK);
		scl_d    = scl_q;
		sda_d    = sda_q;
		busy_d   = busy_q;
		ack_d    = ack_q;
		cmd_d    = cmd_q;
		phase_d  = phase_q;
		hold_d   = hold_q;
		shift_d  = shift_q;
		rx_d     = rx_q;
		done_d   = 1'b0;

		// new command only when idle
		if (start) begin
			busy_d  = 1'b1;
			cmd_d   = item.cmd;
			phase_d = 5'd0;
			hold_d  = 16'd0;
			if (item.cmd == CMD_WRITE) begin
				shift_d = item.tx_byte;
			end else if (item.cmd == CMD_READ) begin
				shift_d = 8'd0;
			end
		end

		ph       = phase_of(cmd_d, phase_d, shift_d);
		n_phases = phase_count(cmd_d);

		if (busy_d) begin
			// line is set on the first tick of a phase
			if (hold_d == 16'd0) begin
				if (ph.line == LINE_SCL) begin
					scl_d = ph.level;
				end else begin
					sda_d = ph.level;
				end
			end
			if (hold_d != HOLD_MAX) begin
				hold_d = hold_d + 16'd1;
			end
			// end of hold: sample, advance, maybe finish
			if (hold_d >= limit) begin
				if (ph.sample) begin
					if (cmd_d == CMD_READ) begin
						shift_d = {shift_d[6:0], item.sda_in};
					end else begin
						ack_d = item.sda_in;
					end
				end
				hold_d  = 16'd0;
				phase_d = phase_d + 5'd1;
				if (phase_d >= n_phases) begin
					if (cmd_d == CMD_READ) begin
						rx_d = shift_d;
					end
					busy_d  = 1'b0;
					phase_d = 5'd0;
					done_d  = 1'b1;
				end
			end
		end

		res.scl_out   = scl_d;
		res.sda_out   = sda_d;
		res.busy_res  = busy_d;
		res.done_res  = done_d;
		res.rx_byte   = rx_d;
		res.ack_level = ack_d;
	end

	// sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			busy_q  <= 1'b0;
			ack_q   <= 1'b0;
			cmd_q   <= CMD_START;
			phase_q <= 5'd0;
			hold_q  <= 16'd0;
			shift_q <= 8'd0;
			rx_q    <= 8'd0;
		end else if (fire) begin
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			busy_q  <= busy_d;
			ack_q   <= ack_d;
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			hold_q  <= hold_d;
			shift_q <= shift_d;
			rx_q    <= rx_d;
		end
	end

endmodule

// File: src/i2cblm_out_reg.sv
module i2cblm_out_reg import i2cblm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	// free when empty or being drained this cycle
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

// File: src/i2c_bit_level_master_unit.sv
// Bit-level I2C master timing engine. Every input transaction is one tick of
// bus time: it may carry a command (start, stop, write byte, read byte, send
// ack, send nack, read ack) with its byte, and always carries the sampled SDA
// level. Every tick yields exactly one result transaction with the SCL/SDA
// drive after that tick, busy/done flags, the last received byte and the last
// sampled ack level. Each line phase is held for cfg_wdata ticks (reset 40,
// zero acts as one); write cfg only while the block is idle. Throughput is one
// tick per clock cycle while m_tready does not stall the output; the phase
// sequencer steps once per accepted tick. Each input passes the input
// register, then the result register; commands during a sequence are dropped.
`include "i2c_bit_level_master_unit_defines.svh"

module i2c_bit_level_master_unit import i2cblm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,   // phase_ticks
	input  logic               s_tvalid,
	output logic               s_tready,
	// cmd_valid[0], cmd[3:1], tx_byte[11:4], sda_in[12], zero pad
	input  logic [TDATA_W-1:0] s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
	// ack_level[12], zero pad
	output logic [TDATA_W-1:0] m_tdata
);

	logic [15:0] phase_ticks_q;
	logic        s1_valid;
	item_t       s1_item;
	logic        res_ready;
	logic        advance;
	res_t        eng_res;
	res_t        out_res;

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// input stage
	assign advance  = s1_valid && res_ready;
	assign s_tready = !s1_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_item <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	i2cblm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.fire        (advance),
		.item        (s1_item),
		.res         (eng_res)
	);

	i2cblm_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_ready  (res_ready),
		.in_res    (eng_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(TDATA_W - $bits(res_t)){1'b0}}, out_res};

	// checks
	`I2CBLM_ASSERT_SAME(a_done_idle, m_tvalid && out_res.done_res, !out_res.busy_res, "done while busy")
	`I2CBLM_ASSERT_NEXT(a_s1_hold, s1_valid && !res_ready, s1_valid && $stable(s1_item), "input stage lost")
	`I2CBLM_ASSERT_NEXT(a_s1_to_out, advance, m_tvalid, "result not registered")

endmodule
